// ===== rtl/core/utf8_character_histogram_unit_macros.svh =====
// Assertion macros shared by the character histogram RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef UTF8_CHARACTER_HISTOGRAM_UNIT_MACROS_SVH
`define UTF8_CHARACTER_HISTOGRAM_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define UTFH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define UTFH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/utfh_pkg.sv =====
// Shared types, codes and helper functions of the character histogram.
// No dependencies; imported by every module of the block.
package utfh_pkg;

	// Width of a decoded code point.
	localparam int CP_W = 21;

	// Request types.
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Status codes reported with every result word.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_OPEN   = 2'd1;
	localparam logic [1:0] ST_ERROR  = 2'd2;
	localparam logic [1:0] ST_HALTED = 2'd3;

	// Bounds on the first continuation byte of a sequence.
	localparam logic [2:0] CLS_ANY   = 3'd0;
	localparam logic [2:0] CLS_E0    = 3'd1;
	localparam logic [2:0] CLS_ED    = 3'd2;
	localparam logic [2:0] CLS_F0    = 3'd3;
	localparam logic [2:0] CLS_F4    = 3'd4;

	// Decoder result for one accepted word.
	typedef struct packed {
		logic            is_read;
		logic            bump;
		logic [CP_W-1:0] cp;
		logic [1:0]      status;
	} dec_t;

	// Non-count part of a finished result word.
	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            char_valid;
		logic [1:0]      status;
	} info_t;

	// Checks a continuation byte against the bound left by the lead byte.
	function automatic logic cont_ok(input logic [7:0] b, input logic [2:0] cls);
		logic ok;
		case (cls)
			CLS_E0: ok = (b >= 8'hA0) && (b <= 8'hBF);
			CLS_ED: ok = (b >= 8'h80) && (b <= 8'h9F);
			CLS_F0: ok = (b >= 8'h90) && (b <= 8'hBF);
			CLS_F4: ok = (b >= 8'h80) && (b <= 8'h8F);
			default: ok = (b >= 8'h80) && (b <= 8'hBF);
		endcase
		return ok;
	endfunction

endpackage

// ===== rtl/core/utfh_decode.sv =====
// UTF-8 sequence decoder with sticky error state of the character histogram.
// Depends on utfh_pkg and the assertion macro header.
`include "utf8_character_histogram_unit_macros.svh"

module utfh_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           byte_mode,
	input  logic           req_type,
	input  logic [7:0]     data_byte,
	input  logic           end_of_input,
	output utfh_pkg::dec_t dec
);
	import utfh_pkg::*;

	logic [CP_W-1:0] partial_q, partial_n;
	logic [1:0]      remain_q, remain_n;
	logic [2:0]      cls_q, cls_n;
	logic            sticky_q, sticky_n;
	logic            err, done;
	logic [CP_W-1:0] joined;

	// Code point with this continuation byte shifted in.
	assign joined = {partial_q[CP_W-7:0], data_byte[5:0]};

	// Next decoder state and the result of this word.
	always_comb begin
		partial_n = partial_q;
		remain_n  = remain_q;
		cls_n     = cls_q;
		sticky_n  = sticky_q;
		err       = 1'b0;
		done      = 1'b0;
		dec       = '0;
		dec.is_read = (req_type == REQ_READ);
		if (req_type == REQ_READ) begin
			dec.status = sticky_q ? ST_HALTED : ((remain_q != 2'd0) ? ST_OPEN : ST_OK);
		end else if (sticky_q) begin
			dec.status = ST_HALTED;
		end else if (byte_mode) begin
			partial_n  = '0;
			remain_n   = 2'd0;
			cls_n      = CLS_ANY;
			dec.bump   = 1'b1;
			dec.cp     = CP_W'(data_byte);
			dec.status = ST_OK;
		end else begin
			if (remain_q == 2'd0) begin
				if (data_byte < 8'h80) begin
					partial_n = CP_W'(data_byte);
					done      = 1'b1;
				end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
					partial_n = CP_W'(data_byte[4:0]);
					remain_n  = 2'd1;
					cls_n     = CLS_ANY;
				end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
					partial_n = CP_W'(data_byte[3:0]);
					remain_n  = 2'd2;
					cls_n     = (data_byte == 8'hE0) ? CLS_E0 :
						((data_byte == 8'hED) ? CLS_ED : CLS_ANY);
				end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
					partial_n = CP_W'(data_byte[2:0]);
					remain_n  = 2'd3;
					cls_n     = (data_byte == 8'hF0) ? CLS_F0 :
						((data_byte == 8'hF4) ? CLS_F4 : CLS_ANY);
				end else begin
					err = 1'b1;
				end
			end else if (cont_ok(data_byte, cls_q)) begin
				partial_n = joined;
				cls_n     = CLS_ANY;
				remain_n  = remain_q - 2'd1;
				done      = (remain_q == 2'd1);
			end else begin
				err = 1'b1;
			end

			// A sequence left open by the last byte is an error.
			if (!err && !done && end_of_input) begin
				err = 1'b1;
			end

			if (err) begin
				partial_n  = '0;
				remain_n   = 2'd0;
				cls_n      = CLS_ANY;
				sticky_n   = 1'b1;
				dec.status = ST_ERROR;
			end else if (done) begin
				dec.cp     = partial_n;
				dec.bump   = 1'b1;
				dec.status = ST_OK;
				partial_n  = '0;
				remain_n   = 2'd0;
				cls_n      = CLS_ANY;
			end else begin
				dec.status = ST_OPEN;
			end
		end
	end

	// Decoder state advances only on accepted words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			remain_q  <= 2'd0;
			cls_q     <= CLS_ANY;
			sticky_q  <= 1'b0;
		end else if (accept) begin
			partial_q <= partial_n;
			remain_q  <= remain_n;
			cls_q     <= cls_n;
			sticky_q  <= sticky_n;
		end
	end

	`UTFH_ASSERT_NEXT(a_err_sticks, clk, arst_n, accept && dec.status == ST_ERROR, sticky_q, "decode error did not halt the decoder")
	`UTFH_ASSERT_NOW(a_halted_no_bump, clk, arst_n, sticky_q, !dec.bump, "halted decoder counted a character")
endmodule

// ===== rtl/core/utfh_count.sv =====
// Counter memory with read-modify-write, forwarding, overflow counter and reset clear.
// Depends on utfh_pkg and the assertion macro header.
`include "utf8_character_histogram_unit_macros.svh"

module utfh_count #(
	parameter int CODE_BITS  = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  utfh_pkg::dec_t                dec,
	input  logic [15:0]                   read_index,
	input  logic                          s1_adv,
	output logic                          s1_valid,
	output logic                          busy,
	output logic [COUNT_BITS-1:0]         res_count,
	output logic [COUNT_BITS-1:0]         res_ovf,
	output utfh_pkg::info_t               res_info
);
	import utfh_pkg::*;

	localparam int DEPTH = 1 << CODE_BITS;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + COUNT_BITS'(1);
	endfunction

	logic [COUNT_BITS-1:0] mem_q [DEPTH];
	logic [COUNT_BITS-1:0] rdata_q;
	logic [CP_W-1:0]       idx_ext;
	logic                  cp_in, rd_in, store_s0;
	logic [CODE_BITS-1:0]  addr_s0;

	logic                  valid_s1, read_s1, bump_s1, store_s1;
	logic [CODE_BITS-1:0]  addr_s1;
	logic [CP_W-1:0]       cp_s1;
	logic [1:0]            status_s1;
	logic [COUNT_BITS-1:0] ovf_s1;
	logic [COUNT_BITS-1:0] beyond_q;

	logic                  wr_valid_q;
	logic [CODE_BITS-1:0]  wr_addr_q;
	logic [COUNT_BITS-1:0] wr_data_q;

	logic                  clr_busy_q;
	logic [CODE_BITS-1:0]  clr_addr_q;

	logic [COUNT_BITS-1:0] cur, nxt;
	logic                  wr_en;

	// Address and store range of the accepted word.
	assign idx_ext  = CP_W'(read_index);
	assign cp_in    = ((dec.cp >> CODE_BITS) == '0);
	assign rd_in    = ((idx_ext >> CODE_BITS) == '0);
	assign store_s0 = dec.is_read ? rd_in : cp_in;
	assign addr_s0  = dec.is_read ? idx_ext[CODE_BITS-1:0] : dec.cp[CODE_BITS-1:0];

	// Current count: the last write wins over the memory word read beside it.
	assign cur   = (wr_valid_q && wr_addr_q == addr_s1) ? wr_data_q : rdata_q;
	assign nxt   = sat_inc(cur);
	assign wr_en = s1_adv && bump_s1 && store_s1;

	// Memory: clearing sweep after reset, then count write-back; registered read.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem_q[addr_s1] <= nxt;
		end
		if (accept) begin
			rdata_q <= mem_q[addr_s0];
		end
	end

	// Clear sweep control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + CODE_BITS'(1);
			if (&clr_addr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Last write, kept for forwarding to the next read of the same entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if (wr_en) begin
			wr_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= nxt;
		end
	end

	// Overflow counter for code points beyond the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beyond_q <= '0;
		end else if (accept && dec.bump && !cp_in) begin
			beyond_q <= sat_inc(beyond_q);
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			read_s1   <= dec.is_read;
			bump_s1   <= dec.bump;
			store_s1  <= store_s0;
			addr_s1   <= addr_s0;
			cp_s1     <= dec.cp;
			status_s1 <= dec.status;
			ovf_s1    <= (dec.bump && !cp_in) ? sat_inc(beyond_q) : beyond_q;
		end
	end

	// Result of the word in stage 1.
	always_comb begin
		res_count = '0;
		if (read_s1) begin
			res_count = store_s1 ? cur : '0;
		end else if (bump_s1) begin
			res_count = store_s1 ? nxt : ovf_s1;
		end
	end

	assign res_ovf             = ovf_s1;
	assign res_info.cp         = cp_s1;
	assign res_info.char_valid = bump_s1;
	assign res_info.status     = status_s1;
	assign s1_valid            = valid_s1;
	assign busy                = clr_busy_q;

	`UTFH_ASSERT_NOW(a_no_accept_clear, clk, arst_n, clr_busy_q, !accept, "word accepted during clear sweep")
	`UTFH_ASSERT_NOW(a_no_write_clear, clk, arst_n, clr_busy_q, !wr_en && !valid_s1, "count write during clear sweep")
	`UTFH_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !s1_adv && !accept, valid_s1 && $stable(addr_s1), "stalled stage 1 word lost")
	`UTFH_ASSERT_NOW(a_accept_free, clk, arst_n, accept && valid_s1, s1_adv, "stage 1 overwritten")
endmodule

// ===== rtl/core/utf8_character_histogram_unit.sv =====
// Pipeline: an accepted word is registered into stage 1, and its result word then into the output register.
// Throughput: one word per cycle while in_stall is low, including repeated characters (write-back forwarding).
// The single counter memory port pair (one read, one write per cycle) sets the rate.
// Reset: asynchronous; afterwards the counter memory is cleared one entry per cycle,
// all 2^CODE_BITS entries in turn, while in_stall is high. Configuration writes are taken at once.
// Depends on utfh_pkg, utfh_decode and utfh_count.
module utf8_character_histogram_unit #(
	parameter int CODE_BITS  = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	input  logic        end_of_input,
	input  logic [15:0] read_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] count_value,
	output logic [20:0] codepoint,
	output logic        char_valid,
	output logic [1:0]  status,
	output logic [31:0] overflow_count
);
	import utfh_pkg::*;

	logic                  byte_mode_q;
	logic                  accept, out_ready, s1_adv, s1_valid, busy;
	dec_t                  dec;
	info_t                 res_info;
	logic [COUNT_BITS-1:0] res_count, res_ovf;
	logic [31:0]           show_count, show_ovf;
	logic                  out_valid_q;

	// Handshake: stage 1 drains into the output register when that is free or taken.
	assign out_ready = !out_valid_q || !out_stall;
	assign s1_adv    = s1_valid && out_ready;
	assign in_stall  = busy || (s1_valid && !out_ready);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			byte_mode_q <= cfg_data;
		end
	end

	utfh_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.byte_mode    (byte_mode_q),
		.req_type     (req_type),
		.data_byte    (data_byte),
		.end_of_input (end_of_input),
		.dec          (dec)
	);

	utfh_count #(
		.CODE_BITS  (CODE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_count (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.dec        (dec),
		.read_index (read_index),
		.s1_adv     (s1_adv),
		.s1_valid   (s1_valid),
		.busy       (busy),
		.res_count  (res_count),
		.res_ovf    (res_ovf),
		.res_info   (res_info)
	);

	// Counts wider than the port are shown saturated.
	generate
		if (COUNT_BITS > 32) begin : g_wide
			assign show_count = (|res_count[COUNT_BITS-1:32]) ? '1 : res_count[31:0];
			assign show_ovf   = (|res_ovf[COUNT_BITS-1:32]) ? '1 : res_ovf[31:0];
		end else begin : g_narrow
			assign show_count = 32'(res_count);
			assign show_ovf   = 32'(res_ovf);
		end
	endgenerate

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= s1_valid;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			count_value    <= show_count;
			codepoint      <= res_info.cp;
			char_valid     <= res_info.char_valid;
			status         <= res_info.status;
			overflow_count <= show_ovf;
		end
	end

	assign out_valid = out_valid_q;
endmodule
